[rtl/core/wprm_pkg.sv]
// Shared widths, constants and controller/datapath interface types for the wheel pulse rate meter.
package wprm_pkg;

  localparam int WHEEL_W       = 2;
  localparam int CFG_W         = 16;
  localparam int COUNT_W       = 17;
  localparam int RATE_W        = 24;
  localparam int US_W          = 26;
  localparam int NUM_W         = COUNT_W + US_W;
  localparam int STEP_W        = $clog2(RATE_W);

  localparam int WHEELS_DEF    = 4;
  localparam int TIME_BITS_DEF = 48;

  localparam logic [US_W-1:0]   US_PER_MINUTE = US_W'(60000000);
  localparam logic [CFG_W-1:0]  PPU_RESET     = CFG_W'(100);
  localparam logic [RATE_W-1:0] RATE_MAX      = '1;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic check;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic no_result;
    logic sat_now;
    logic out_free;
  } st_t;

endpackage

[rtl/core/wheel_pulse_rate_meter.sv]
// Top level of the wheel pulse rate meter: controller, datapath and assertions.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in       | in_valid / in_ready       | in_wheel, in_timestamp_us
//  out      | out_valid / out_ready     | out_wheel_out, out_pulses_per_minute,
//           |                           | out_saturated
//  cfg      | cfg_valid / cfg_ready     | cfg_pulses_per_update
//
// A pulse that produces no rate passes through the transfer, then the counter update.
// A pulse that produces a rate passes through transfer, lookup and multiply,
// saturation check, 24 restoring divide steps (one quotient bit per cycle), and
// the load into the result register; a saturated rate skips the divide.
// The result register frees the input side: the next pulse is taken while a rate
// still waits on out_ready; only a second rate stalls until the first leaves.
// Synchronous active-low reset clears all counters, window starts and sets the
// threshold to 100. cfg_ready is always high.
module wheel_pulse_rate_meter
  import wprm_pkg::*;
#(
  parameter int WHEELS    = WHEELS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WHEEL_W-1:0]   in_wheel,
  input  logic [TIME_BITS-1:0] in_timestamp_us,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WHEEL_W-1:0]   out_wheel_out,
  output logic [RATE_W-1:0]    out_pulses_per_minute,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_pulses_per_update
);

  cmd_t cmd;
  st_t  st;

  // Threshold writes land immediately; the register lives in the datapath.
  assign cfg_ready = 1'b1;

  wprm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  wprm_datapath #(
    .WHEELS    (WHEELS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .in_wheel              (in_wheel),
    .in_timestamp_us       (in_timestamp_us),
    .cfg_valid             (cfg_valid),
    .cfg_pulses_per_update (cfg_pulses_per_update),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_wheel_out         (out_wheel_out),
    .out_pulses_per_minute (out_pulses_per_minute),
    .out_saturated         (out_saturated)
  );

  // Hold at most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.lookup, cmd.check, cmd.div_step, cmd.load_out}))
    else $error("more than one datapath command active");

  // Never overwrite a rate that has not been transferred.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  // Drop in_ready for at least the lookup cycle after each input transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && cmd.lookup))
    else $error("input taken without lookup");

  // Raise out_valid only after a result load.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("out_valid raised without a load");

endmodule

[rtl/core/wprm_datapath.sv]
// Datapath: per-wheel counters and window starts, multiplier, shift-subtract divider, result register.
module wprm_datapath
  import wprm_pkg::*;
#(
  parameter int WHEELS    = WHEELS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output st_t                  st,
  input  logic [WHEEL_W-1:0]   in_wheel,
  input  logic [TIME_BITS-1:0] in_timestamp_us,
  input  logic                 cfg_valid,
  input  logic [CFG_W-1:0]     cfg_pulses_per_update,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [WHEEL_W-1:0]   out_wheel_out,
  output logic [RATE_W-1:0]    out_pulses_per_minute,
  output logic                 out_saturated
);

  localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int SAT_W = TIME_BITS + RATE_W;

  logic [CFG_W-1:0]     ppu_r;
  logic [COUNT_W-1:0]   cnt_r  [WHEELS];
  logic [TIME_BITS-1:0] last_r [WHEELS];

  logic [WHEEL_W-1:0]   wheel_r;
  logic [TIME_BITS-1:0] ts_r;
  logic [NUM_W-1:0]     prod_r;
  logic [TIME_BITS-1:0] dt_r;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0]    lo_r;
  logic [RATE_W-1:0]    q_r;
  logic                 sat_r;
  logic                 out_valid_r;
  logic [WHEEL_W-1:0]   out_wheel_r;
  logic [RATE_W-1:0]    out_rate_r;
  logic                 out_sat_r;

  logic [IDX_W-1:0]     idx;
  logic                 wheel_ok;
  logic [COUNT_W-1:0]   cnt_inc;
  logic                 over;
  logic [TIME_BITS:0]   rem_sh;
  logic                 rem_ge;

  assign idx      = IDX_W'(wheel_r);
  assign wheel_ok = (int'(wheel_r) < WHEELS);
  assign cnt_inc  = cnt_r[idx] + COUNT_W'(1);
  assign over     = cnt_inc > COUNT_W'(ppu_r);

  assign st.no_result = !wheel_ok || !over;
  // A zero interval also lands here: the product is never zero.
  assign st.sat_now   = SAT_W'(prod_r) >= {dt_r, RATE_W'(0)};
  assign st.out_free  = !out_valid_r || out_ready;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  assign rem_sh  = {rem_r, lo_r[RATE_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dt_r};
  assign rem_nxt = rem_ge ? TIME_BITS'(rem_sh - {1'b0, dt_r}) : TIME_BITS'(rem_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppu_r       <= PPU_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WHEELS; i++) begin
        cnt_r[i]  <= '0;
        last_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        ppu_r <= cfg_pulses_per_update;
      end
      if (cmd.lookup && wheel_ok) begin
        if (over) begin
          cnt_r[idx]  <= '0;
          last_r[idx] <= ts_r;
        end else begin
          cnt_r[idx] <= cnt_inc;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wheel_r <= in_wheel;
      ts_r    <= in_timestamp_us;
    end
    if (cmd.lookup) begin
      prod_r <= NUM_W'(cnt_inc) * NUM_W'(US_PER_MINUTE);
      dt_r   <= ts_r - last_r[idx];
    end
    if (cmd.check) begin
      sat_r <= st.sat_now;
      q_r   <= RATE_MAX;
      rem_r <= TIME_BITS'(prod_r >> RATE_W);
      lo_r  <= prod_r[RATE_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[RATE_W-2:0], 1'b0};
      q_r   <= {q_r[RATE_W-2:0], rem_ge};
    end
    if (cmd.load_out) begin
      out_wheel_r <= wheel_r;
      out_rate_r  <= q_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_wheel_out         = out_wheel_r;
  assign out_pulses_per_minute = out_rate_r;
  assign out_saturated         = out_sat_r;

endmodule

[rtl/core/wprm_ctrl.sv]
// Controller: sequences lookup, saturation check, divide steps and result load.
module wprm_ctrl
  import wprm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  st_t  st,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_DIV,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              step_last;

  assign step_last = (step_r == STEP_W'(RATE_W - 1));

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = st.no_result ? S_IDLE : S_CHECK;
      end
      S_CHECK: begin
        step_nxt  = '0;
        state_nxt = st.sat_now ? S_OUT : S_DIV;
      end
      S_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.lookup   = (state_r == S_LOOK);
  assign cmd.check    = (state_r == S_CHECK);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.load_out = (state_r == S_OUT) && st.out_free;

endmodule

[dv/wheel_pulse_rate_meter_tb.sv]
// Testbench for the wheel pulse rate meter: directed corner cases, random pulse streams, backpressure.
`timescale 1ns / 1ps

module wheel_pulse_rate_meter_tb
  import wprm_pkg::*;
();

  localparam int TIME_W         = 48;
  localparam int N_WHEELS       = 4;
  // Give the block margin to finish any pulse before touching the register.
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  // Several times the longest quiet stretch of a correct run (the long hold-off).
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_GAP        = 12;

  localparam logic [CFG_W-1:0] PPU_ZERO = '0;
  localparam logic [CFG_W-1:0] PPU_MAX  = '1;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [RATE_W-1:0]  ppm;
    logic               sat;
  } rate_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [WHEEL_W-1:0]   in_wheel = '0;
  logic [TIME_W-1:0]    in_timestamp_us = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WHEEL_W-1:0]   out_wheel_out;
  logic [RATE_W-1:0]    out_pulses_per_minute;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_pulses_per_update = '0;

  // Shadow of the block: per-wheel pulse counters, window starts, and the threshold.
  logic [COUNT_W-1:0]   win_count [N_WHEELS];
  logic [TIME_W-1:0]    win_start [N_WHEELS];
  logic [CFG_W-1:0]     ppu_shadow;
  rate_t                pending_rates [$];

  int                   err_count = 0;
  int                   quiet_cycles = 0;
  // Idling switch and hold-off request; both are written with NBAs by the stimulus side.
  logic                 idle_on = 1'b1;
  logic                 hold_tgl = 1'b0;
  logic                 hold_seen = 1'b0;
  int                   hold_left = 0;
  int                   rx_wait = 0;
  rate_t                want;
  // Free-running time base for well-formed pulse streams.
  logic [TIME_W-1:0]    now_us = '0;

  always #5 clk = ~clk;

  wheel_pulse_rate_meter #(
    .WHEELS    (N_WHEELS),
    .TIME_BITS (TIME_W)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_wheel              (in_wheel),
    .in_timestamp_us       (in_timestamp_us),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_wheel_out         (out_wheel_out),
    .out_pulses_per_minute (out_pulses_per_minute),
    .out_saturated         (out_saturated),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_pulses_per_update (cfg_pulses_per_update)
  );

  // Advance the shadow by one accepted pulse; queue the rate it produces, if any.
  function automatic void predict_pulse(input logic [WHEEL_W-1:0] w,
                                        input logic [TIME_W-1:0] ts);
    logic [COUNT_W-1:0] cnt;
    logic [TIME_W-1:0]  dt;
    logic [63:0]        quo;
    rate_t              r;
    cnt = win_count[w] + 1'b1;
    win_count[w] = cnt;
    if (cnt <= {1'b0, ppu_shadow})
      return;
    // Window length wraps with the timestamp.
    dt = ts - win_start[w];
    r.wheel = w;
    r.sat = 1'b0;
    if (dt == '0) begin
      r.ppm = RATE_MAX;
      r.sat = 1'b1;
    end else begin
      quo = (64'(cnt) * 64'd60000000) / 64'(dt);
      if (quo > 64'(RATE_MAX)) begin
        r.ppm = RATE_MAX;
        r.sat = 1'b1;
      end else begin
        r.ppm = quo[RATE_W-1:0];
      end
    end
    win_start[w] = ts;
    win_count[w] = '0;
    pending_rates.push_back(r);
  endfunction

  // Draw the next timestamp: mostly a forward-moving clock, some noise and wrap jumps.
  function automatic logic [TIME_W-1:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      return TIME_W'({$urandom, $urandom});
    if (pick < 15)
      now_us += TIME_W'($urandom_range(0, 3));
    else if (pick < 75)
      now_us += TIME_W'($urandom_range(1, 20000));
    else if (pick < 97)
      now_us += TIME_W'($urandom);
    else
      now_us = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 50000));
    return now_us;
  endfunction

  // Offer one pulse, after a random gap when idling is on, and hold it until the transfer.
  task automatic send_pulse(input logic [WHEEL_W-1:0] w, input logic [TIME_W-1:0] ts);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_wheel        <= w;
    in_timestamp_us <= ts;
    do @(posedge clk); while (!in_ready);
    predict_pulse(w, ts);
  endtask

  // Drop valid, wait for every rate to come out, then let any counter update finish.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the threshold only once the block is idle.
  task automatic write_ppu(input logic [CFG_W-1:0] v);
    drain_block();
    cfg_valid             <= 1'b1;
    cfg_pulses_per_update <= v;
    do @(posedge clk); while (!cfg_ready);
    ppu_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  // First window of every wheel is measured from time zero.
  task automatic test_first_window();
    write_ppu(PPU_ZERO);
    send_pulse(2'd0, '0);                 // zero interval from reset
    send_pulse(2'd1, 48'd1);              // far too fast, clips
    send_pulse(2'd2, '1);                 // longest window, rate rounds to zero
    send_pulse(2'd3, 48'd3_600_000);      // 16 pulses per minute
  endtask

  // Two pulses with the same stamp on one wheel.
  task automatic test_zero_interval();
    send_pulse(2'd0, 48'd5000);
    send_pulse(2'd0, 48'd5000);
  endtask

  // Straddle the output limit: 4 us still fits, 3 us clips.
  task automatic test_saturation_edge();
    send_pulse(2'd1, 48'd5);
    send_pulse(2'd1, 48'd8);
  endtask

  // Count under the highest threshold, then lower it to at most the running counts.
  task automatic test_lowered_threshold();
    int k;
    write_ppu(PPU_MAX);
    for (k = 0; k < 4; k++)
      send_pulse(2'd3, 48'd10_000_000 + TIME_W'(k * 1000));
    send_pulse(2'd2, 48'd20_000_000);
    send_pulse(2'd2, 48'd20_500_000);
    write_ppu(16'd2);
    send_pulse(2'd3, 48'd10_010_000);
    send_pulse(2'd2, 48'd21_000_000);
  endtask

  // Window that spans the timestamp wrap, plus alternating bit patterns.
  task automatic test_timestamp_wrap();
    write_ppu(PPU_ZERO);
    send_pulse(2'd0, 48'hFFFF_FFFF_F000);
    send_pulse(2'd0, 48'h0000_0000_0800);
    send_pulse(2'd1, 48'hAAAA_AAAA_AAAA);
    send_pulse(2'd1, 48'h5555_5555_5555);
  endtask

  // Phases of random pulse streams, each under its own threshold.
  task automatic test_random_streams();
    logic [CFG_W-1:0] ppu_plan [10];
    int               p;
    int               i;
    int               n;
    ppu_plan = '{16'd0, 16'd3, 16'd1, PPU_MAX, 16'd2, 16'd7, 16'd0,
                 CFG_W'($urandom), 16'd4, 16'd1};
    for (p = 0; p < 10; p++) begin
      write_ppu(ppu_plan[p]);
      // Keep some phases free of idling on both sides.
      idle_on <= (p % 3 != 2);
      n = (ppu_plan[p] > 16) ? 20 : 120;
      for (i = 0; i < n; i++)
        send_pulse(WHEEL_W'($urandom_range(0, N_WHEELS - 1)), next_stamp());
    end
  endtask

  // Hold the result side off for a long stretch while pulses keep coming.
  task automatic test_backpressure();
    int i;
    write_ppu(PPU_ZERO);
    idle_on  <= 1'b0;
    hold_tgl <= ~hold_tgl;
    for (i = 0; i < 30; i++)
      send_pulse(WHEEL_W'($urandom_range(0, N_WHEELS - 1)), next_stamp());
    idle_on <= 1'b1;
  endtask

  // Result side: check each transfer against the oldest expected rate, then pick the
  // next ready pattern (long hold-off first, else a random wait after each transfer while idling is on).
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rates.size() == 0) begin
        $error("unexpected rate: wheel %0d, ppm %0d, sat %0d",
               out_wheel_out, out_pulses_per_minute, out_saturated);
        err_count++;
      end else begin
        want = pending_rates.pop_front();
        if (out_wheel_out !== want.wheel) begin
          $error("wheel_out: expected %0d, got %0d", want.wheel, out_wheel_out);
          err_count++;
        end
        if (out_pulses_per_minute !== want.ppm) begin
          $error("pulses_per_minute: expected %0d, got %0d",
                 want.ppm, out_pulses_per_minute);
          err_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, out_saturated);
          err_count++;
        end
      end
      rx_wait = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < N_WHEELS; i++) begin
      win_count[i] = '0;
      win_start[i] = '0;
    end
    ppu_shadow = PPU_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_window();
    test_zero_interval();
    test_saturation_edge();
    test_lowered_threshold();
    test_timestamp_wrap();
    test_random_streams();
    test_backpressure();

    drain_block();
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
